// ===== hdl/volcu_pkg.sv =====
`timescale 1ns / 1ps

package volcu_pkg;

    localparam int ODDS_W  = 24;
    localparam int RGB_W   = 24;
    localparam int SAMP_W  = 16;
    localparam int MARK_W  = 2;
    localparam int OP_W    = 3;
    localparam int IDX_W   = 12;
    localparam int CLASS_W = 2;
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam int CH_W    = 8;
    localparam int CH_N    = 3;
    localparam int DVS_W   = SAMP_W + 1;

    localparam logic [OP_W-1:0] OP_HIT   = 3'd0;
    localparam logic [OP_W-1:0] OP_MISS  = 3'd1;
    localparam logic [OP_W-1:0] OP_COLOR = 3'd2;
    localparam logic [OP_W-1:0] OP_QUERY = 3'd3;
    localparam logic [OP_W-1:0] OP_END   = 3'd4;

    localparam logic [2:0] REG_HIT_GAIN  = 3'd0;
    localparam logic [2:0] REG_MISS_GAIN = 3'd1;
    localparam logic [2:0] REG_UPPER     = 3'd2;
    localparam logic [2:0] REG_LOWER     = 3'd3;
    localparam logic [2:0] REG_THRESHOLD = 3'd4;

    localparam logic [CLASS_W-1:0] CLASS_FREE     = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_UNKNOWN  = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_OCCUPIED = 2'd2;

    localparam logic signed [ODDS_W-1:0] HIT_GAIN_RST  = 24'sd847298;
    localparam logic signed [ODDS_W-1:0] MISS_GAIN_RST = -24'sd405465;
    localparam logic signed [ODDS_W-1:0] UPPER_RST     = 24'sd3476099;
    localparam logic signed [ODDS_W-1:0] LOWER_RST     = -24'sd1992430;
    localparam logic signed [ODDS_W-1:0] THRESHOLD_RST = 24'sd0;

    localparam logic signed [ODDS_W:0] ODDS_MAX = 25'sd8388607;
    localparam logic signed [ODDS_W:0] ODDS_MIN = -25'sd8388608;

    localparam logic [SAMP_W-1:0] SAMPLES_MAX = 16'hFFFF;
    localparam logic [MARK_W-1:0] ROUND_FIRST = 2'd1;
    localparam logic [MARK_W-1:0] ROUND_LAST  = 2'd3;
    localparam logic [1:0]        DIV_LAST    = 2'd3;

    typedef struct packed {
        logic                     known;
        logic signed [ODDS_W-1:0] odds;
        logic [MARK_W-1:0]        mark;
        logic [RGB_W-1:0]         rgb;
        logic [SAMP_W-1:0]        samples;
    } t_cell;

    typedef struct packed {
        logic signed [ODDS_W-1:0] hit_gain;
        logic signed [ODDS_W-1:0] miss_gain;
        logic signed [ODDS_W-1:0] upper_clamp;
        logic signed [ODDS_W-1:0] lower_clamp;
        logic signed [ODDS_W-1:0] threshold;
    } t_cfg;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ADDR,
        S_EXEC,
        S_DIV,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic clear;
        logic accept;
        logic addr;
        logic exec;
        logic div_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic            clear_last;
        logic            out_free;
        logic [OP_W-1:0] op;
    } t_status;

endpackage

// ===== hdl/volcu_regs.sv =====
`timescale 1ns / 1ps

module volcu_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [volcu_pkg::PADDR_W-1:0] paddr,
    input  logic [volcu_pkg::PDATA_W-1:0] pwdata,
    output logic [volcu_pkg::PDATA_W-1:0] prdata,
    output logic                          pready,
    output volcu_pkg::t_cfg               o_cfg
);
    import volcu_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] w_index;
    logic       w_write;

    assign w_index = paddr[4:2];
    assign w_write = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hit_gain    <= HIT_GAIN_RST;
            r_cfg.miss_gain   <= MISS_GAIN_RST;
            r_cfg.upper_clamp <= UPPER_RST;
            r_cfg.lower_clamp <= LOWER_RST;
            r_cfg.threshold   <= THRESHOLD_RST;
        end else if (w_write) begin
            case (w_index)
                REG_HIT_GAIN:  r_cfg.hit_gain    <= pwdata[ODDS_W-1:0];
                REG_MISS_GAIN: r_cfg.miss_gain   <= pwdata[ODDS_W-1:0];
                REG_UPPER:     r_cfg.upper_clamp <= pwdata[ODDS_W-1:0];
                REG_LOWER:     r_cfg.lower_clamp <= pwdata[ODDS_W-1:0];
                REG_THRESHOLD: r_cfg.threshold   <= pwdata[ODDS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_index)
            REG_HIT_GAIN:  prdata = {{8{r_cfg.hit_gain[ODDS_W-1]}}, r_cfg.hit_gain};
            REG_MISS_GAIN: prdata = {{8{r_cfg.miss_gain[ODDS_W-1]}}, r_cfg.miss_gain};
            REG_UPPER:     prdata = {{8{r_cfg.upper_clamp[ODDS_W-1]}}, r_cfg.upper_clamp};
            REG_LOWER:     prdata = {{8{r_cfg.lower_clamp[ODDS_W-1]}}, r_cfg.lower_clamp};
            REG_THRESHOLD: prdata = {{8{r_cfg.threshold[ODDS_W-1]}}, r_cfg.threshold};
            default:       prdata = '0;
        endcase
    end

endmodule

// ===== hdl/volcu_ctrl.sv =====
`timescale 1ns / 1ps

module volcu_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  volcu_pkg::t_status i_status,
    output volcu_pkg::t_cmd    o_cmd
);
    import volcu_pkg::*;

    t_state     r_state;
    t_state     n_state;
    logic [1:0] r_div_cnt;
    logic [1:0] n_div_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_div_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_div_cnt <= n_div_cnt;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_div_cnt = '0;
        o_cmd     = '0;
        o_ready   = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_status.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_ADDR;
                end
            end
            S_ADDR: begin
                o_cmd.addr = 1'b1;
                n_state    = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_status.op == OP_COLOR) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_div_cnt      = r_div_cnt + 2'd1;
                if (r_div_cnt == DIV_LAST) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/volcu_dp.sv =====
`timescale 1ns / 1ps

module volcu_dp #(
    parameter int CELLS = 4096
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  volcu_pkg::t_cmd                      i_cmd,
    output volcu_pkg::t_status                   o_status,
    input  volcu_pkg::t_cfg                      i_cfg,
    input  logic [volcu_pkg::OP_W-1:0]           i_operation,
    input  logic [volcu_pkg::IDX_W-1:0]          i_cell_index,
    input  logic [volcu_pkg::RGB_W-1:0]          i_color_rgb,
    input  logic                                 i_ready,
    output logic                                 o_valid,
    output logic [volcu_pkg::CLASS_W-1:0]        o_cell_class,
    output logic signed [volcu_pkg::ODDS_W-1:0]  o_cell_log_odds,
    output logic [volcu_pkg::RGB_W-1:0]          o_cell_color,
    output logic                                 o_was_applied
);
    import volcu_pkg::*;

    localparam int AW = $clog2(CELLS);
    localparam int unsigned RECIP = (2 ** 24) / CELLS;

    t_cell mem [CELLS];

    logic [OP_W-1:0]         r_op;
    logic [IDX_W-1:0]        r_idx;
    logic [RGB_W-1:0]        r_rgb;
    logic [7:0]              r_q;
    logic [AW-1:0]           r_addr;
    logic [AW-1:0]           r_clear_cnt;
    t_cell                   r_rd;
    logic [MARK_W-1:0]       r_round;
    logic signed [ODDS_W:0]  r_sum;
    logic                    r_applied;
    logic [DVS_W-1:0]        r_dvs;
    logic [DVS_W-1:0]        r_rem [CH_N];
    logic [CH_W-1:0]         r_quo [CH_N];
    logic                    r_out_valid;
    logic [CLASS_W-1:0]      r_class;
    logic signed [ODDS_W-1:0] r_odds;
    logic [RGB_W-1:0]        r_color;
    logic                    r_was_applied;

    logic [31:0]             w_prod;
    logic [31:0]             w_rem;
    logic [31:0]             w_red;
    logic [AW-1:0]           w_addr;
    t_cell                   w_base;
    t_cell                   w_new;
    t_cell                   w_wdata;
    logic [AW-1:0]           w_waddr;
    logic                    w_we;
    logic                    w_is_hm;
    logic signed [ODDS_W-1:0] w_gain;
    logic signed [ODDS_W:0]  w_clamped;
    logic signed [ODDS_W-1:0] w_sat;
    logic [RGB_W-1:0]        w_num [CH_N];
    logic [DVS_W-1:0]        w_rem_nx [CH_N];
    logic [CH_W-1:0]         w_quo_nx [CH_N];
    logic [CLASS_W-1:0]      w_class;

    // Index reduction modulo CELLS: reciprocal estimate, then one correction.
    assign w_prod = 32'(i_cell_index) * 32'(RECIP);
    assign w_rem  = 32'(r_idx) - 32'(r_q) * 32'(CELLS);
    assign w_red  = (w_rem >= 32'(CELLS)) ? (w_rem - 32'(CELLS)) : w_rem;
    assign w_addr = AW'(w_red);

    assign w_is_hm = (r_op == OP_HIT) || (r_op == OP_MISS);
    assign w_gain  = (r_op == OP_HIT) ? i_cfg.hit_gain : i_cfg.miss_gain;

    always_comb begin
        w_base = r_rd;
        if (!r_rd.known) begin
            w_base       = '0;
            w_base.known = 1'b1;
        end
    end

    always_comb begin
        for (int ch = 0; ch < CH_N; ch++) begin
            w_num[ch] = 24'(w_base.rgb[ch*CH_W +: CH_W]) * 24'(w_base.samples)
                      + 24'(r_rgb[ch*CH_W +: CH_W]);
        end
    end

    // Two restoring division steps per cycle on each channel.
    always_comb begin
        logic [DVS_W-1:0] p;
        logic [CH_W-1:0]  q;
        logic [DVS_W:0]   t;
        for (int ch = 0; ch < CH_N; ch++) begin
            p = r_rem[ch];
            q = r_quo[ch];
            for (int k = 0; k < 2; k++) begin
                t = {p, q[CH_W-1]};
                q = {q[CH_W-2:0], 1'b0};
                if (t >= {1'b0, r_dvs}) begin
                    t    = t - {1'b0, r_dvs};
                    q[0] = 1'b1;
                end
                p = t[DVS_W-1:0];
            end
            w_rem_nx[ch] = p;
            w_quo_nx[ch] = q;
        end
    end

    always_comb begin
        w_clamped = r_sum;
        if (r_op == OP_HIT) begin
            if (r_sum > $signed({i_cfg.upper_clamp[ODDS_W-1], i_cfg.upper_clamp})) begin
                w_clamped = {i_cfg.upper_clamp[ODDS_W-1], i_cfg.upper_clamp};
            end
        end else begin
            if (r_sum < $signed({i_cfg.lower_clamp[ODDS_W-1], i_cfg.lower_clamp})) begin
                w_clamped = {i_cfg.lower_clamp[ODDS_W-1], i_cfg.lower_clamp};
            end
        end
        if (w_clamped > ODDS_MAX) begin
            w_sat = ODDS_MAX[ODDS_W-1:0];
        end else if (w_clamped < ODDS_MIN) begin
            w_sat = ODDS_MIN[ODDS_W-1:0];
        end else begin
            w_sat = w_clamped[ODDS_W-1:0];
        end
    end

    always_comb begin
        w_new = r_rd;
        case (r_op)
            OP_HIT, OP_MISS: begin
                w_new = w_base;
                if (r_applied) begin
                    w_new.odds = w_sat;
                    w_new.mark = r_round;
                end
            end
            OP_COLOR: begin
                w_new     = w_base;
                w_new.rgb = {r_quo[2], r_quo[1], r_quo[0]};
                if (w_base.samples != SAMPLES_MAX) begin
                    w_new.samples = w_base.samples + 16'd1;
                end
            end
            default: begin
                w_new = r_rd;
            end
        endcase
    end

    always_comb begin
        if (!w_new.known) begin
            w_class = CLASS_UNKNOWN;
        end else if ($signed(w_new.odds) > $signed(i_cfg.threshold)) begin
            w_class = CLASS_OCCUPIED;
        end else if ($signed(w_new.odds) < $signed(i_cfg.threshold)) begin
            w_class = CLASS_FREE;
        end else begin
            w_class = CLASS_UNKNOWN;
        end
    end

    assign w_we    = i_cmd.clear | (i_cmd.finish & (w_is_hm | (r_op == OP_COLOR)));
    assign w_waddr = i_cmd.clear ? r_clear_cnt : r_addr;
    assign w_wdata = i_cmd.clear ? t_cell'('0) : w_new;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (i_cmd.addr) begin
            r_rd <= mem[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clear_cnt <= '0;
            r_round     <= ROUND_FIRST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_clear_cnt <= r_clear_cnt + AW'(1);
            end
            if (i_cmd.exec && r_op == OP_END) begin
                r_round <= (r_round == ROUND_LAST) ? ROUND_FIRST : r_round + 2'd1;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op  <= i_operation;
            r_idx <= i_cell_index;
            r_rgb <= i_color_rgb;
            r_q   <= w_prod[31:24];
        end
        if (i_cmd.addr) begin
            r_addr <= w_addr;
        end
        if (i_cmd.exec) begin
            r_sum     <= $signed({w_base.odds[ODDS_W-1], w_base.odds})
                       + $signed({w_gain[ODDS_W-1], w_gain});
            r_applied <= (w_base.mark != r_round);
            r_dvs     <= DVS_W'(w_base.samples) + 17'd1;
            for (int ch = 0; ch < CH_N; ch++) begin
                r_rem[ch] <= {1'b0, w_num[ch][RGB_W-1:CH_W]};
                r_quo[ch] <= w_num[ch][CH_W-1:0];
            end
        end else if (i_cmd.div_step) begin
            for (int ch = 0; ch < CH_N; ch++) begin
                r_rem[ch] <= w_rem_nx[ch];
                r_quo[ch] <= w_quo_nx[ch];
            end
        end
        if (i_cmd.finish) begin
            r_class       <= w_class;
            r_odds        <= w_new.known ? w_new.odds : '0;
            r_color       <= w_new.known ? w_new.rgb : '0;
            r_was_applied <= w_is_hm & r_applied;
        end
    end

    assign o_status.clear_last = (r_clear_cnt == AW'(CELLS - 1));
    assign o_status.out_free   = ~r_out_valid | i_ready;
    assign o_status.op         = r_op;

    assign o_valid         = r_out_valid;
    assign o_cell_class    = r_class;
    assign o_cell_log_odds = r_odds;
    assign o_cell_color    = r_color;
    assign o_was_applied   = r_was_applied;

endmodule

// ===== hdl/voxel_log_odds_color_update_unit.sv =====
`timescale 1ns / 1ps

// Voxel occupancy and color table with one operation per item.
// The input channel (i_valid / o_ready) carries an operation, a cell index
// and a color sample. The output channel (o_valid / i_ready) returns one item
// per input item: the class, log-odds and averaged color of the addressed cell
// after the operation, and whether a hit or miss changed the cell.
// Hit, miss, query and end of scan pass through the accept, address, execute
// and finish states. A color sample also passes the divide state, since the
// per-channel dividers form the three 8-bit channel averages two bits a cycle.
// Hit, miss and color items do one read-modify-write of the cell memory.
// The APB port sets the gains, clamps and threshold; write them only while
// the block is idle.
// After reset the block clears the known flag of every cell, one cell per
// cycle, and o_ready stays low until the last cell is cleared; register writes
// are taken during that time. The scan round restarts at one.
// A finished result waits in an output register. If the receiver stalls, the
// block still accepts the next item and stops only when that item's result
// is ready and the output register is still full.
module voxel_log_odds_color_update_unit #(
    parameter int CELLS = 4096
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [volcu_pkg::OP_W-1:0]           i_operation,
    input  logic [volcu_pkg::IDX_W-1:0]          i_cell_index,
    input  logic [volcu_pkg::RGB_W-1:0]          i_color_rgb,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [volcu_pkg::CLASS_W-1:0]        o_cell_class,
    output logic signed [volcu_pkg::ODDS_W-1:0]  o_cell_log_odds,
    output logic [volcu_pkg::RGB_W-1:0]          o_cell_color,
    output logic                                 o_was_applied,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [volcu_pkg::PADDR_W-1:0]        paddr,
    input  logic [volcu_pkg::PDATA_W-1:0]        pwdata,
    output logic [volcu_pkg::PDATA_W-1:0]        prdata,
    output logic                                 pready
);
    import volcu_pkg::*;

    t_cfg    w_cfg;
    t_cmd    w_cmd;
    t_status w_status;

    volcu_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    volcu_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    volcu_dp #(
        .CELLS (CELLS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_cfg           (w_cfg),
        .i_operation     (i_operation),
        .i_cell_index    (i_cell_index),
        .i_color_rgb     (i_color_rgb),
        .i_ready         (i_ready),
        .o_valid         (o_valid),
        .o_cell_class    (o_cell_class),
        .o_cell_log_odds (o_cell_log_odds),
        .o_cell_color    (o_cell_color),
        .o_was_applied   (o_was_applied)
    );

endmodule
